// File: src/rtu_pkg.sv
`timescale 1ns / 1ps
package rtu_pkg;
   localparam logic [3:0] OP_LINE_BYTE = 4'd0;
   localparam logic [3:0] OP_T35       = 4'd1;
   localparam logic [3:0] OP_TX_EMPTY  = 4'd2;
   localparam logic [3:0] OP_LOAD      = 4'd3;
   localparam logic [3:0] OP_SEND      = 4'd4;
   localparam logic [3:0] OP_CHECK     = 4'd5;
   localparam logic [3:0] OP_READ      = 4'd6;
   localparam logic [3:0] OP_START     = 4'd7;
   localparam logic [3:0] OP_STOP      = 4'd8;

   localparam logic [2:0] EV_NONE      = 3'd0;
   localparam logic [2:0] EV_LINK_UP   = 3'd1;
   localparam logic [2:0] EV_FRAME_RX  = 3'd2;
   localparam logic [2:0] EV_FRAME_TX  = 3'd3;
   localparam logic [2:0] EV_TIMEOUT   = 3'd4;

   localparam logic [2:0] TM_NONE    = 3'd0;
   localparam logic [2:0] TM_T35     = 3'd1;
   localparam logic [2:0] TM_STOP    = 3'd2;
   localparam logic [2:0] TM_CONVERT = 3'd3;
   localparam logic [2:0] TM_RESPOND = 3'd4;

   localparam logic [1:0] RX_INIT  = 2'd0;
   localparam logic [1:0] RX_IDLE  = 2'd1;
   localparam logic [1:0] RX_RCV   = 2'd2;
   localparam logic [1:0] RX_ERROR = 2'd3;
   localparam logic [1:0] TX_IDLE  = 2'd0;
   localparam logic [1:0] TX_XMIT  = 2'd1;
   localparam logic [1:0] TX_WAIT  = 2'd2;

   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   typedef struct packed {
      logic       status;
      logic [2:0] event_res;
      logic       execute_event;
      logic [2:0] timer_action;
      logic       port_update;
      logic       rx_enable;
      logic       tx_enable;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic [7:0] frame_address;
      logic [7:0] frame_length;
      logic [7:0] read_value;
   } result_type;

   // controller to datapath
   typedef struct packed {
      logic start;      // latch item fields
      logic crc_clear;
      logic crc_step;   // fold one buffer byte
      logic mem_rd;     // issue buffer read at crc position
      logic finish;     // apply item effect, build result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_crc;   // item needs a crc walk
      logic crc_last;   // last byte is being folded
   } stat_type;

   function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] d);
      logic [15:0] x;
      x = c ^ {8'h00, d};
      for (int b = 0; b < 8; b++) begin
         x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
      end
      return x;
   endfunction
endpackage

// File: src/rtu_serial_frame_engine_top.sv
`timescale 1ns / 1ps
// an accepted item goes through decode and finish, then its result is held until taken
// check (with at least MIN_FRAME bytes) and an accepted send walk the crc one buffer byte
// a cycle over n bytes, n = received frame bytes for check, pdu length + 1 for send
// one item at a time; the next is taken the cycle after the result is taken,
// so an item passes the idle, decode, finish and result states, prime and crc with a walk
// synchronous active-high reset: receiver init, transmitter idle, counters zero,
// frame buffer contents are undefined after reset
module rtu_serial_frame_engine_top
   import rtu_pkg::*;
#(
   parameter int BUFFER_BYTES = 256,
   parameter int MIN_FRAME = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [3:0] req_operation,
   input  logic [7:0] req_data_byte,
   input  logic [7:0] req_buffer_index,
   input  logic [7:0] req_slave_address,
   input  logic [7:0] req_pdu_length,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_status,
   output logic [2:0] rsp_event_res,
   output logic       rsp_execute_event,
   output logic [2:0] rsp_timer_action,
   output logic       rsp_port_update,
   output logic       rsp_rx_enable,
   output logic       rsp_tx_enable,
   output logic       rsp_tx_valid,
   output logic [7:0] rsp_tx_byte,
   output logic [7:0] rsp_frame_address,
   output logic [7:0] rsp_frame_length,
   output logic [7:0] rsp_read_value
);
   // master mode register, written only while idle
   logic master_ff;
   assign csr_ready = req_ready;
   always_ff @(posedge clock) begin
      if (reset) master_ff <= 1'b0;
      else if (csr_valid && csr_ready) master_ff <= csr_data;
   end

   cmd_type    cmd;
   stat_type   stat;
   result_type res;

   // sequencer: accept, optional crc walk, finish, hold result
   rtu_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .stat, .cmd
   );

   // buffer, crc unit and framer state
   rtu_dp #(.BUFFER_BYTES(BUFFER_BYTES), .MIN_FRAME(MIN_FRAME)) u_dp (
      .clock, .reset, .master_mode(master_ff),
      .req_operation, .req_data_byte, .req_buffer_index,
      .req_slave_address, .req_pdu_length,
      .cmd, .stat, .result(res)
   );

   assign rsp_status        = res.status;
   assign rsp_event_res     = res.event_res;
   assign rsp_execute_event = res.execute_event;
   assign rsp_timer_action  = res.timer_action;
   assign rsp_port_update   = res.port_update;
   assign rsp_rx_enable     = res.rx_enable;
   assign rsp_tx_enable     = res.tx_enable;
   assign rsp_tx_valid      = res.tx_valid;
   assign rsp_tx_byte       = res.tx_byte;
   assign rsp_frame_address = res.frame_address;
   assign rsp_frame_length  = res.frame_length;
   assign rsp_read_value    = res.read_value;

   // no new item while a result waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("item accepted with result pending");

   // a result only carries a tx byte when tx_valid
   a_tx_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_tx_valid) |-> rsp_tx_byte == 8'd0)
      else $error("tx byte without tx valid");

   // port enables only with a port update
   a_port: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_port_update) |-> (!rsp_rx_enable && !rsp_tx_enable))
      else $error("enable without port update");
endmodule

// File: src/rtu_ctrl.sv
`timescale 1ns / 1ps
module rtu_ctrl
   import rtu_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);
   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_DECODE= 6'b000010,
      S_PRIME = 6'b000100,
      S_CRC   = 6'b001000,
      S_FIN   = 6'b010000,
      S_RESP  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.crc_clear = 1'b1;
            cmd.mem_rd = 1'b1;
            state_in = stat.need_crc ? S_PRIME : S_FIN;
         end
         S_PRIME: begin
            cmd.mem_rd = 1'b1;
            state_in = S_CRC;
         end
         S_CRC: begin
            cmd.crc_step = 1'b1;
            cmd.mem_rd = 1'b1;
            if (stat.crc_last) state_in = S_FIN;
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule

// File: src/rtu_dp.sv
`timescale 1ns / 1ps
module rtu_dp
   import rtu_pkg::*;
#(
   parameter int BUFFER_BYTES = 256,
   parameter int MIN_FRAME = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       master_mode,
   input  logic [3:0] req_operation,
   input  logic [7:0] req_data_byte,
   input  logic [7:0] req_buffer_index,
   input  logic [7:0] req_slave_address,
   input  logic [7:0] req_pdu_length,
   input  cmd_type    cmd,
   output stat_type   stat,
   output result_type result
);
   localparam int AW = $clog2(BUFFER_BYTES);
   localparam int CW = $clog2(BUFFER_BYTES + 1);

   logic [7:0] mem [BUFFER_BYTES];
   logic [7:0] rdata_ff;

   logic [3:0] op_ff;
   logic [7:0] dbyte_ff, addr_ff, plen_ff;
   logic [8:0] pos_ff;
   logic [1:0] rx_state_ff, tx_state_ff;
   logic [CW-1:0] rx_count_ff;
   logic [AW-1:0] tx_pos_ff;
   logic [10:0] tx_rem_ff;
   logic bcast_ff, delay_ff;
   logic [15:0] crc_ff;
   logic [10:0] rd_cnt_ff, fold_cnt_ff, crc_len_ff;
   result_type res_ff;
   logic [7:0] rdata0_ff;

   result_type    result_in;
   logic [1:0]    rx_state_in, tx_state_in;
   logic [CW-1:0] rx_count_in;
   logic [AW-1:0] tx_pos_in;
   logic [10:0]   tx_rem_in;
   logic          bcast_in, delay_in;

   logic [10:0] crc_len;
   logic [10:0] send_total;
   logic        send_ok, check_len_ok, pos_ok;
   assign send_total = {3'b000, plen_ff} + 11'd3;
   assign send_ok = (rx_state_ff == RX_IDLE) && (send_total <= 11'(BUFFER_BYTES));
   assign check_len_ok = (rx_count_ff >= CW'(MIN_FRAME));
   assign pos_ok = ({2'b00, pos_ff} < 11'(BUFFER_BYTES));
   assign crc_len = (op_ff == OP_SEND) ? ({3'b000, plen_ff} + 11'd1) : 11'(rx_count_ff);

   assign stat.need_crc = ((op_ff == OP_SEND) && send_ok) ||
                          ((op_ff == OP_CHECK) && check_len_ok);
   assign stat.crc_last = (fold_cnt_ff + 11'd1 >= crc_len_ff);

   // read address: crc walk, tx byte, or read op
   logic [AW-1:0] raddr;
   always_comb begin
      if (cmd.mem_rd && (stat.need_crc || cmd.crc_step)) raddr = AW'(rd_cnt_ff);
      else if (op_ff == OP_TX_EMPTY) raddr = tx_pos_ff;
      else raddr = AW'(pos_ff);
   end

   // the send address byte stands in for entry 0 during the walk
   logic [7:0] fold_byte;
   assign fold_byte = (op_ff == OP_SEND && fold_cnt_ff == 11'd0) ? addr_ff : rdata_ff;

   logic [15:0] crc_next;
   assign crc_next = crc_byte(crc_ff, fold_byte);

   // write port
   logic          we;
   logic [AW-1:0] waddr;
   logic [7:0]    wdata;
   logic [1:0]    crc_wr_ff;
   logic [AW-1:0] crc_wa_ff;
   always_comb begin
      we = 1'b0; waddr = '0; wdata = '0;
      if (crc_wr_ff != 2'd0) begin
         we = 1'b1;
         waddr = crc_wa_ff;
         wdata = (crc_wr_ff == 2'd2) ? crc_ff[7:0] : crc_ff[15:8];
      end else if (cmd.finish) begin
         unique case (op_ff)
            OP_LINE_BYTE: begin
               if (rx_state_ff == RX_IDLE) begin
                  we = 1'b1; waddr = '0; wdata = dbyte_ff;
               end else if (rx_state_ff == RX_RCV && rx_count_ff < CW'(BUFFER_BYTES)) begin
                  we = 1'b1; waddr = AW'(rx_count_ff); wdata = dbyte_ff;
               end
            end
            OP_LOAD: begin
               we = pos_ok; waddr = AW'(pos_ff); wdata = dbyte_ff;
            end
            OP_SEND: begin
               we = send_ok; waddr = '0; wdata = addr_ff;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   // the prime cycle reads entry 0, each fold cycle reads one entry ahead
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff <= req_operation;
         dbyte_ff <= req_data_byte;
         pos_ff <= {1'b0, req_buffer_index} + 9'd1;
         addr_ff <= req_slave_address;
         plen_ff <= req_pdu_length;
      end
      if (cmd.crc_clear) begin
         crc_ff <= CRC_INIT;
         rd_cnt_ff <= '0;
         fold_cnt_ff <= '0;
         crc_len_ff <= crc_len;
      end else if (cmd.crc_step) begin
         crc_ff <= crc_next;
         fold_cnt_ff <= fold_cnt_ff + 11'd1;
         rd_cnt_ff <= rd_cnt_ff + 11'd1;
      end else if (cmd.mem_rd) begin
         rd_cnt_ff <= rd_cnt_ff + 11'd1;
      end
      if (cmd.finish) res_ff <= result_in;
   end

   assign result = res_ff;

   // crc bytes go back into the buffer after the send step
   always_ff @(posedge clock) begin
      if (reset) crc_wr_ff <= 2'd0;
      else if (cmd.finish && op_ff == OP_SEND && send_ok) crc_wr_ff <= 2'd2;
      else if (crc_wr_ff == 2'd2) crc_wr_ff <= 2'd1;
      else crc_wr_ff <= 2'd0;
      if (cmd.finish) crc_wa_ff <= AW'(plen_ff) + AW'(1);
      else if (crc_wr_ff == 2'd2) crc_wa_ff <= crc_wa_ff + AW'(1);
   end

   always_comb begin
      result_in = '0;
      rx_state_in = rx_state_ff; tx_state_in = tx_state_ff;
      rx_count_in = rx_count_ff; tx_pos_in = tx_pos_ff;
      tx_rem_in = tx_rem_ff; bcast_in = bcast_ff; delay_in = delay_ff;
      case (op_ff)
         OP_LINE_BYTE: begin
            if (rx_state_ff == RX_IDLE) begin
               if (master_mode) tx_state_in = TX_IDLE;
               rx_count_in = CW'(1);
               rx_state_in = RX_RCV;
            end else if (rx_state_ff == RX_RCV) begin
               if (rx_count_ff < CW'(BUFFER_BYTES)) rx_count_in = rx_count_ff + CW'(1);
               else rx_state_in = RX_ERROR;
            end
            result_in.timer_action = TM_T35;
            delay_in = 1'b0;
         end
         OP_T35: begin
            if (rx_state_ff == RX_INIT) result_in.event_res = EV_LINK_UP;
            else if (rx_state_ff == RX_RCV) result_in.event_res = EV_FRAME_RX;
            result_in.timer_action = TM_STOP;
            rx_state_in = RX_IDLE;
            if (master_mode) begin
               if (tx_state_ff == TX_WAIT && !bcast_ff) result_in.event_res = EV_TIMEOUT;
               tx_state_in = TX_IDLE;
               result_in.execute_event = delay_ff;
            end
         end
         OP_TX_EMPTY: begin
            if (tx_state_ff == TX_IDLE) begin
               result_in.port_update = 1'b1; result_in.rx_enable = 1'b1;
            end else if (tx_state_ff == TX_XMIT) begin
               if (tx_rem_ff != 11'd0) begin
                  result_in.tx_valid = 1'b1;
                  result_in.tx_byte = rdata_ff;
                  tx_pos_in = tx_pos_ff + AW'(1);
                  tx_rem_in = tx_rem_ff - 11'd1;
               end else if (master_mode) begin
                  result_in.port_update = 1'b1; result_in.rx_enable = 1'b1;
                  tx_state_in = TX_WAIT;
                  result_in.timer_action = bcast_ff ? TM_CONVERT : TM_RESPOND;
                  delay_in = bcast_ff;
               end else begin
                  result_in.event_res = EV_FRAME_TX;
                  result_in.port_update = 1'b1; result_in.rx_enable = 1'b1;
                  tx_state_in = TX_IDLE;
               end
            end
         end
         OP_SEND: begin
            if (!send_ok) result_in.status = 1'b1;
            else begin
               bcast_in = (addr_ff == 8'd0);
               tx_pos_in = '0;
               tx_rem_in = send_total;
               tx_state_in = TX_XMIT;
               result_in.port_update = 1'b1; result_in.tx_enable = 1'b1;
            end
         end
         OP_CHECK: begin
            if (check_len_ok && crc_ff == 16'd0) begin
               result_in.frame_address = rdata0_ff;
               result_in.frame_length = 8'(rx_count_ff - CW'(3));
            end else result_in.status = 1'b1;
         end
         OP_READ: if (pos_ok) result_in.read_value = rdata_ff;
         OP_START: begin
            rx_state_in = RX_INIT;
            result_in.port_update = 1'b1; result_in.rx_enable = 1'b1;
            result_in.timer_action = TM_T35;
            delay_in = 1'b0;
         end
         OP_STOP: begin
            result_in.port_update = 1'b1;
            result_in.timer_action = TM_STOP;
         end
         default: ;
      endcase
   end

   // first byte of the walk is the frame address
   always_ff @(posedge clock) begin
      if (cmd.crc_step && fold_cnt_ff == 11'd0) rdata0_ff <= rdata_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_state_ff <= RX_INIT; tx_state_ff <= TX_IDLE;
         rx_count_ff <= '0; tx_pos_ff <= '0; tx_rem_ff <= '0;
         bcast_ff <= 1'b0; delay_ff <= 1'b0;
      end else if (cmd.finish) begin
         rx_state_ff <= rx_state_in; tx_state_ff <= tx_state_in;
         rx_count_ff <= rx_count_in; tx_pos_ff <= tx_pos_in; tx_rem_ff <= tx_rem_in;
         bcast_ff <= bcast_in; delay_ff <= delay_in;
      end
   end
endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;
   import rtu_pkg::*;

   typedef struct {
      logic [3:0] op;
      logic [7:0] data;
      logic [7:0] index;
      logic [7:0] address;
      logic [7:0] length;
   } frame_op_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_data = 1'b0;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [3:0] req_operation = '0;
   logic [7:0] req_data_byte = '0;
   logic [7:0] req_buffer_index = '0;
   logic [7:0] req_slave_address = '0;
   logic [7:0] req_pdu_length = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   result_type rsp;

   rtu_serial_frame_engine_top i_dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_operation(req_operation), .req_data_byte(req_data_byte),
      .req_buffer_index(req_buffer_index), .req_slave_address(req_slave_address),
      .req_pdu_length(req_pdu_length),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp.status), .rsp_event_res(rsp.event_res),
      .rsp_execute_event(rsp.execute_event), .rsp_timer_action(rsp.timer_action),
      .rsp_port_update(rsp.port_update), .rsp_rx_enable(rsp.rx_enable),
      .rsp_tx_enable(rsp.tx_enable), .rsp_tx_valid(rsp.tx_valid),
      .rsp_tx_byte(rsp.tx_byte), .rsp_frame_address(rsp.frame_address),
      .rsp_frame_length(rsp.frame_length), .rsp_read_value(rsp.read_value)
   );

   always #10 clock = ~clock;

   // items waiting for the driver and results waiting for the monitor
   frame_op_type pending_ops[$];
   result_type   expected_results[$];

   // shadow of the framer state, advanced as items are queued
   logic [1:0] sh_rx_state, sh_tx_state;
   logic [7:0] sh_buffer[256];
   bit         sh_written[256];
   int         sh_rx_count, sh_tx_pos, sh_tx_left;
   bit         sh_broadcast, sh_delay, sh_master;

   int  error_count = 0;
   int  queued_count = 0;
   int  frames_ok = 0;
   int  frames_sent = 0;
   int  idle_cycles = 0;
   bit  calm = 1'b0;        // no idling on either side
   bit  hold_send = 1'b0;   // sender paused by the sequence
   int  hold_requests = 0;
   int  hold_served = 0;
   int  send_gap = 0;
   int  recv_stall = 0;
   int  recv_hold = 0;

   function automatic logic [15:0] buffer_crc(int count);
      logic [15:0] c;
      c = 16'hFFFF;
      for (int i = 0; i < count && i < 256; i++) begin
         c ^= {8'h00, sh_buffer[i]};
         for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      end
      return c;
   endfunction

   // advance the shadow state by one item and return its result
   function automatic result_type framer_step(frame_op_type it);
      result_type r;
      int pos, total, n;
      logic [15:0] c;
      r = '0;
      pos = int'(it.index) + 1;
      case (it.op)
         OP_LINE_BYTE: begin
            if (sh_rx_state == RX_IDLE) begin
               if (sh_master) sh_tx_state = TX_IDLE;
               sh_buffer[0] = it.data; sh_written[0] = 1;
               sh_rx_count = 1;
               sh_rx_state = RX_RCV;
            end else if (sh_rx_state == RX_RCV) begin
               if (sh_rx_count < 256) begin
                  sh_buffer[sh_rx_count] = it.data; sh_written[sh_rx_count] = 1;
                  sh_rx_count++;
               end else sh_rx_state = RX_ERROR;
            end
            r.timer_action = TM_T35;
            sh_delay = 0;
         end
         OP_T35: begin
            if (sh_rx_state == RX_INIT) r.event_res = EV_LINK_UP;
            else if (sh_rx_state == RX_RCV) r.event_res = EV_FRAME_RX;
            r.timer_action = TM_STOP;
            sh_rx_state = RX_IDLE;
            if (sh_master) begin
               if (sh_tx_state == TX_WAIT && !sh_broadcast) r.event_res = EV_TIMEOUT;
               sh_tx_state = TX_IDLE;
               if (sh_delay) r.execute_event = 1;
            end
         end
         OP_TX_EMPTY: begin
            if (sh_tx_state == TX_IDLE) begin
               r.port_update = 1; r.rx_enable = 1;
            end else if (sh_tx_state == TX_XMIT) begin
               if (sh_tx_left != 0) begin
                  r.tx_valid = 1;
                  r.tx_byte = sh_buffer[sh_tx_pos];
                  sh_tx_pos = (sh_tx_pos + 1) % 256;
                  sh_tx_left--;
               end else if (sh_master) begin
                  r.port_update = 1; r.rx_enable = 1;
                  sh_tx_state = TX_WAIT;
                  r.timer_action = sh_broadcast ? TM_CONVERT : TM_RESPOND;
                  sh_delay = sh_broadcast;
               end else begin
                  r.event_res = EV_FRAME_TX;
                  r.port_update = 1; r.rx_enable = 1;
                  sh_tx_state = TX_IDLE;
               end
            end
         end
         OP_LOAD: if (pos < 256) begin
            sh_buffer[pos] = it.data; sh_written[pos] = 1;
         end
         OP_SEND: begin
            total = int'(it.length) + 3;
            if (sh_rx_state != RX_IDLE || total > 256) r.status = 1;
            else begin
               sh_broadcast = (it.address == 0);
               sh_buffer[0] = it.address; sh_written[0] = 1;
               n = int'(it.length) + 1;
               c = buffer_crc(n);
               sh_buffer[n] = c[7:0]; sh_written[n] = 1;
               sh_buffer[n + 1] = c[15:8]; sh_written[n + 1] = 1;
               sh_tx_pos = 0;
               sh_tx_left = total;
               sh_tx_state = TX_XMIT;
               r.port_update = 1; r.tx_enable = 1;
            end
         end
         OP_CHECK: begin
            if (sh_rx_count >= 4 && sh_rx_count <= 256 && buffer_crc(sh_rx_count) == 0) begin
               r.frame_address = sh_buffer[0];
               r.frame_length = 8'(sh_rx_count - 3);
            end else r.status = 1;
         end
         OP_READ: if (pos < 256) r.read_value = sh_buffer[pos];
         OP_START: begin
            sh_rx_state = RX_INIT;
            r.port_update = 1; r.rx_enable = 1;
            r.timer_action = TM_T35;
            sh_delay = 0;
         end
         OP_STOP: begin
            r.port_update = 1;
            r.timer_action = TM_STOP;
         end
         default: ;
      endcase
      return r;
   endfunction

   // queue one item together with its predicted result
   task automatic queue_op(logic [3:0] op, logic [7:0] data = 0, logic [7:0] index = 0,
                           logic [7:0] address = 0, logic [7:0] length = 0);
      frame_op_type it;
      result_type r;
      it.op = op; it.data = data; it.index = index; it.address = address; it.length = length;
      r = framer_step(it);
      if (op == OP_CHECK && r.status == 0) frames_ok++;
      if (op == OP_SEND && r.status == 0) frames_sent++;
      pending_ops.push_back(it);
      expected_results.push_back(r);
      queued_count++;
   endtask

   // buffer entries read by a send or a read must hold data first
   task automatic fill_gaps(int last);
      for (int p = 1; p <= last && p < 256; p++)
         if (!sh_written[p]) queue_op(OP_LOAD, 8'($urandom), 8'(p - 1));
   endtask

   task automatic read_at(logic [7:0] index);
      fill_gaps(int'(index) + 1);
      queue_op(OP_READ, 0, index);
   endtask

   // closes any reception, puts a whole frame on the line, checks it and reads up to two entries
   task automatic receive_frame(int pdu_len, bit corrupt, logic [7:0] address);
      logic [7:0] bytes[$];
      logic [15:0] c;
      int k;
      bytes.push_back(address);
      for (int i = 0; i < pdu_len; i++) bytes.push_back(8'($urandom));
      c = 16'hFFFF;
      foreach (bytes[i]) begin
         c ^= {8'h00, bytes[i]};
         for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      end
      bytes.push_back(c[7:0]);
      bytes.push_back(c[15:8]);
      if (corrupt) begin
         k = $urandom_range(0, bytes.size() - 1);
         bytes[k] ^= 8'(1 << $urandom_range(0, 7));
      end
      queue_op(OP_T35);
      foreach (bytes[i]) queue_op(OP_LINE_BYTE, bytes[i]);
      queue_op(OP_T35);
      queue_op(OP_CHECK);
      repeat ($urandom_range(0, 2)) read_at(8'($urandom_range(0, pdu_len)));
   endtask

   // load a pdu, send it and drain the transmitter
   task automatic send_frame(int pdu_len, logic [7:0] address);
      if (sh_rx_state != RX_IDLE) queue_op(OP_T35);
      for (int i = 0; i < pdu_len; i++)
         if ($urandom_range(0, 1)) queue_op(OP_LOAD, 8'($urandom), 8'(i));
      fill_gaps(pdu_len);
      queue_op(OP_SEND, 0, 0, address, 8'(pdu_len));
      repeat (pdu_len + 4 + $urandom_range(0, 1)) queue_op(OP_TX_EMPTY);
      if (sh_master && $urandom_range(0, 3) != 0) queue_op(OP_T35);
   endtask

   // random item of any code, kept clear of never-written entries
   task automatic noise_op();
      logic [3:0] op;
      logic [7:0] idx, len;
      op = 4'($urandom_range(0, 15));
      idx = 8'($urandom_range(0, 254));
      len = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 253)) : 8'($urandom_range(0, 12));
      if (op == OP_READ) fill_gaps(int'(idx) + 1);
      if (op == OP_SEND) fill_gaps(int'(len));
      queue_op(op, 8'($urandom), idx, 8'($urandom), len);
   endtask

   task automatic pdu_len_pick(output int n);
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(24, 48) : $urandom_range(0, 16);
   endtask

   task automatic wait_drained();
      while (pending_ops.size() != 0 || expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_mode(bit value);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sh_master = value;
   endtask

   // driver: holds each item until it is accepted, with random gaps
   always @(posedge clock) begin
      frame_op_type it;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else if (!req_valid || req_ready) begin
         if (send_gap > 0 || hold_send || pending_ops.size() == 0) begin
            req_valid <= 1'b0;
            if (send_gap > 0) send_gap <= send_gap - 1;
         end else begin
            it = pending_ops.pop_front();
            req_operation <= it.op;
            req_data_byte <= it.data;
            req_buffer_index <= it.index;
            req_slave_address <= it.address;
            req_pdu_length <= it.length;
            req_valid <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 15);
         end
      end
   end

   task automatic check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
         error_count++;
      end
   endtask

   // monitor: compares each accepted result with the oldest prediction
   always @(posedge clock) begin
      result_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result with no item outstanding", $time);
               error_count++;
            end else begin
               e = expected_results.pop_front();
               check_field("status", e.status, rsp.status);
               check_field("event_res", e.event_res, rsp.event_res);
               check_field("execute_event", e.execute_event, rsp.execute_event);
               check_field("timer_action", e.timer_action, rsp.timer_action);
               check_field("port_update", e.port_update, rsp.port_update);
               check_field("rx_enable", e.rx_enable, rsp.rx_enable);
               check_field("tx_enable", e.tx_enable, rsp.tx_enable);
               check_field("tx_valid", e.tx_valid, rsp.tx_valid);
               check_field("tx_byte", e.tx_byte, rsp.tx_byte);
               check_field("frame_address", e.frame_address, rsp.frame_address);
               check_field("frame_length", e.frame_length, rsp.frame_length);
               check_field("read_value", e.read_value, rsp.read_value);
            end
         end
         if (hold_requests != hold_served) begin
            hold_served <= hold_requests;
            recv_hold <= 400;
            rsp_ready <= 1'b0;
         end else if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            rsp_ready <= 1'b0;
         end else if (recv_stall > 0) begin
            recv_stall <= recv_stall - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0) recv_stall <= $urandom_range(1, 15);
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else if (!reset) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= 5000) begin
            $display("%0t: no progress, giving up", $time);
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      int n, pick, target;
      sh_rx_state = RX_INIT; sh_tx_state = TX_IDLE;
      sh_rx_count = 0; sh_tx_pos = 0; sh_tx_left = 0;
      sh_broadcast = 0; sh_delay = 0; sh_master = 0;
      foreach (sh_buffer[i]) begin
         sh_buffer[i] = 0; sh_written[i] = 0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_mode(1'b0);

      // directed: ignored byte in init, ready event, unused codes, stop/start
      queue_op(OP_LINE_BYTE, 8'hFF);
      queue_op(OP_T35);
      queue_op(OP_T35);                       // expiry while idle
      queue_op(4'd9, 8'hFF, 8'hFE, 8'hFF, 8'hFD);
      queue_op(4'd15, 8'hAA, 8'h55, 8'hAA, 8'h55);
      queue_op(OP_STOP);
      queue_op(OP_START);
      queue_op(OP_CHECK);                     // nothing received yet
      queue_op(OP_LOAD, 8'hFF, 8'd254);
      queue_op(OP_READ, 0, 8'd254);
      queue_op(OP_TX_EMPTY);                  // transmitter already idle
      receive_frame(2, 0, 8'hFF);
      receive_frame(1, 1, 8'h00);
      queue_op(OP_T35);
      queue_op(OP_LINE_BYTE, 8'h11);
      queue_op(OP_LINE_BYTE, 8'h22);
      queue_op(OP_SEND, 0, 0, 8'h01, 8'd1);   // receiver busy
      queue_op(OP_T35);
      queue_op(OP_CHECK);                     // too short
      send_frame(0, 8'h00);
      send_frame(3, 8'hFF);
      wait_drained();

      // overflow: one byte more than the buffer holds
      queue_op(OP_T35);
      repeat (257) queue_op(OP_LINE_BYTE, 8'($urandom));
      queue_op(OP_T35);                       // error state gives no event
      queue_op(OP_CHECK);
      queue_op(OP_SEND, 0, 0, 8'h01, 8'd254); // frame longer than the buffer

      for (int phase = 0; phase < 4; phase++) begin
         wait_drained();
         write_mode(phase[0]);
         if (phase == 1) hold_requests++;    // long receiver hold-off
         if (phase == 3) calm = 1'b1;
         target = queued_count + 30;
         while (queued_count < target) begin
            pick = $urandom_range(0, 9);
            pdu_len_pick(n);
            if (pick < 4) receive_frame(n, 0, 8'($urandom));
            else if (pick == 4) receive_frame($urandom_range(0, 3), 1, 8'($urandom));
            else if (pick < 8)
               send_frame(n, ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
            else repeat ($urandom_range(1, 4)) noise_op();
            if (phase == 2 && $urandom_range(0, 3) == 0) begin
               // sender waits for every outstanding result
               hold_send = 1'b1;
               while (expected_results.size() != pending_ops.size()) @(posedge clock);
               hold_send = 1'b0;
            end
            @(posedge clock);
         end
      end

      while (pending_ops.size() != 0 || expected_results.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("ran %0d items in slave and master mode: %0d frames passed the check, %0d sent",
               queued_count, frames_ok, frames_sent);
      $display("includes overflow, corrupted and short frames, broadcast and timeout events");
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
